@@ rtl/core/orq_pkg.sv @@
package orq_pkg;

	localparam int MAX_ROWS      = 16;
	localparam int MAX_ROW_BYTES = 32;
	localparam int ROW_W         = $clog2(MAX_ROWS);
	localparam int COL_W         = $clog2(MAX_ROW_BYTES);
	localparam int LEN_W         = COL_W;
	localparam int STORE_DEPTH   = MAX_ROWS * MAX_ROW_BYTES;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int BYTE_W        = 8;
	localparam int ROWS_CFG_W    = 5;
	localparam int BYTES_CFG_W   = 6;
	localparam int OCC_W         = 5;
	localparam int APB_AW        = 3;
	localparam int APB_DW        = 32;
	localparam int REG_IDX_LSB   = 2;

	localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = ROWS_CFG_W'(16);
	localparam logic [BYTES_CFG_W-1:0] BYTES_RESET = BYTES_CFG_W'(32);

	typedef enum logic {
		ST_IDLE,
		ST_DEQ
	} orq_state_t;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} orq_op_t;

	typedef enum logic {
		REG_ROWS      = 1'b0,
		REG_ROW_BYTES = 1'b1
	} orq_reg_t;

	// rows register clamped to 1..MAX_ROWS
	function automatic logic [OCC_W-1:0] eff_rows(input logic [ROWS_CFG_W-1:0] cfg);
		logic [OCC_W-1:0] r;
		if (cfg == '0) begin
			r = OCC_W'(1);
		end else if (OCC_W'(cfg) > OCC_W'(MAX_ROWS)) begin
			r = OCC_W'(MAX_ROWS);
		end else begin
			r = OCC_W'(cfg);
		end
		return r;
	endfunction

	// bytes a string may keep: clamped row width minus one
	function automatic logic [COL_W-1:0] eff_limit(input logic [BYTES_CFG_W-1:0] cfg);
		logic [BYTES_CFG_W-1:0] c;
		c = cfg;
		if (c < BYTES_CFG_W'(2)) begin
			c = BYTES_CFG_W'(2);
		end else if (c > BYTES_CFG_W'(MAX_ROW_BYTES)) begin
			c = BYTES_CFG_W'(MAX_ROW_BYTES);
		end
		return COL_W'(c - BYTES_CFG_W'(1));
	endfunction

	function automatic logic [ROW_W-1:0] advance(input logic [ROW_W-1:0] idx,
		input logic [OCC_W-1:0] rows);
		logic [OCC_W:0] nxt;
		nxt = (OCC_W+1)'(idx) + (OCC_W+1)'(1);
		return (nxt >= (OCC_W+1)'(rows)) ? '0 : ROW_W'(nxt);
	endfunction

	function automatic logic [STORE_AW-1:0] row_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		return STORE_AW'(row) * STORE_AW'(MAX_ROW_BYTES) + STORE_AW'(col);
	endfunction

endpackage

@@ rtl/core/orq_if.sv @@
interface orq_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [orq_pkg::BYTE_W-1:0] in_byte;
	logic                       has_byte;
	logic                       is_last;

	modport source (output valid, op, in_byte, has_byte, is_last, input ready);
	modport sink (input valid, op, in_byte, has_byte, is_last, output ready);
endinterface

interface orq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [orq_pkg::BYTE_W-1:0] out_byte;
	logic                       byte_valid;
	logic                       out_last;
	logic                       was_empty;
	logic [orq_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, out_byte, byte_valid, out_last, was_empty, occupancy,
		input ready);
	modport sink (input valid, out_byte, byte_valid, out_last, was_empty, occupancy,
		output ready);
endinterface

@@ rtl/core/overwrite_ring_queue_of_strings_unit.sv @@
// enqueue: one per cycle when ready, no result; is_last moves tail and count, and head if full
// dequeue on an empty queue: its one result is valid in the cycle after the transaction
// dequeue of a stored row: length and first byte come from the memories, so the first result is
// loaded from their read registers once the output is free, then one per cycle while results are taken
// next transaction is taken as the last result drains; a stalled result holds off enqueues too
// reset: asynchronous, clears pointers, count, fill index and output valid; memories keep contents
module overwrite_ring_queue_of_strings_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [orq_pkg::APB_AW-1:0]  paddr,
	input  logic [orq_pkg::APB_DW-1:0]  pwdata,
	output logic [orq_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	orq_req_if.sink                     req,
	orq_rsp_if.source                   rsp
);
	import orq_pkg::*;

	logic [ROWS_CFG_W-1:0]  rows_cfg_q;
	logic [BYTES_CFG_W-1:0] bytes_cfg_q;
	orq_reg_t               reg_sel;

	orq_state_t             state_q, state_d;
	logic [ROW_W-1:0]       head_q, head_d, tail_q, tail_d, rd_row_q, rd_row_d;
	logic [OCC_W-1:0]       occ_q, occ_d;
	logic [COL_W-1:0]       fill_q, fill_d, fill_new, k_q, k_d;

	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q, out_byte_d;
	logic                   byte_valid_q, byte_valid_d;
	logic                   out_last_q, out_last_d;
	logic                   was_empty_q, was_empty_d;
	logic [OCC_W-1:0]       occupancy_q, occupancy_d;
	logic                   load_out;

	logic [OCC_W-1:0]       rows;
	logic [COL_W-1:0]       limit;
	logic                   out_free;
	logic                   acc;
	logic                   last_byte;

	logic                   store_we, store_re;
	logic [STORE_AW-1:0]    store_waddr, store_raddr;
	logic [BYTE_W-1:0]      store_rdata;
	logic                   len_we, len_re;
	logic [LEN_W-1:0]       len_wdata, len_rdata;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = orq_reg_t'(paddr[REG_IDX_LSB]);

	always_comb begin
		unique case (reg_sel)
			REG_ROWS:      prdata = APB_DW'(rows_cfg_q);
			REG_ROW_BYTES: prdata = APB_DW'(bytes_cfg_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= ROWS_RESET;
			bytes_cfg_q <= BYTES_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_ROWS:      rows_cfg_q  <= pwdata[ROWS_CFG_W-1:0];
				REG_ROW_BYTES: bytes_cfg_q <= pwdata[BYTES_CFG_W-1:0];
				default:       ;
			endcase
		end
	end

	// memories
	orq_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (req.in_byte),
		.re    (store_re),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	orq_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_ROWS)
	) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (tail_q),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (head_q),
		.rdata (len_rdata)
	);

	assign rows        = eff_rows(rows_cfg_q);
	assign limit       = eff_limit(bytes_cfg_q);
	assign out_free    = !out_valid_q || rsp.ready;
	assign req.ready   = (state_q == ST_IDLE) && out_free;
	assign acc         = req.valid && req.ready;
	assign store_waddr = row_addr(tail_q, fill_q);
	assign last_byte   = ((COL_W+1)'(k_q) + (COL_W+1)'(1)) == (COL_W+1)'(len_rdata);

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		occ_d        = occ_q;
		fill_d       = fill_q;
		fill_new     = fill_q;
		rd_row_d     = rd_row_q;
		k_d          = k_q;
		store_we     = 1'b0;
		store_re     = 1'b0;
		store_raddr  = row_addr(head_q, '0);
		len_we       = 1'b0;
		len_re       = 1'b0;
		len_wdata    = '0;
		load_out     = 1'b0;
		out_byte_d   = out_byte_q;
		byte_valid_d = byte_valid_q;
		out_last_d   = out_last_q;
		was_empty_d  = was_empty_q;
		occupancy_d  = occupancy_q;

		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (orq_op_t'(req.op) == OP_ENQ) begin
						if (req.has_byte && fill_q < limit) begin
							store_we = 1'b1;
							fill_new = fill_q + COL_W'(1);
						end
						if (req.is_last) begin
							len_we    = 1'b1;
							len_wdata = (fill_new < limit) ? fill_new : limit;
							// full ring: overwrite the oldest row
							if (occ_q >= rows) begin
								head_d = advance(head_q, rows);
								occ_d  = rows;
							end else begin
								occ_d = occ_q + OCC_W'(1);
							end
							tail_d = advance(tail_q, rows);
							fill_d = '0;
						end else begin
							fill_d = fill_new;
						end
					end else if (occ_q == '0) begin
						load_out     = 1'b1;
						out_byte_d   = '0;
						byte_valid_d = 1'b0;
						out_last_d   = 1'b1;
						was_empty_d  = 1'b1;
						occupancy_d  = '0;
					end else begin
						// fetch length and first byte of the head row together
						store_re = 1'b1;
						len_re   = 1'b1;
						rd_row_d = head_q;
						k_d      = '0;
						occ_d    = occ_q - OCC_W'(1);
						head_d   = advance(head_q, rows);
						state_d  = ST_DEQ;
					end
				end
			end
			ST_DEQ: begin
				if (out_free) begin
					load_out    = 1'b1;
					was_empty_d = 1'b0;
					occupancy_d = occ_q;
					if (len_rdata == '0) begin
						out_byte_d   = '0;
						byte_valid_d = 1'b0;
						out_last_d   = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						out_byte_d   = store_rdata;
						byte_valid_d = 1'b1;
						out_last_d   = last_byte;
						if (last_byte) begin
							state_d = ST_IDLE;
						end else begin
							// ram output holds while stalled, next read only on a load
							k_d         = k_q + COL_W'(1);
							store_re    = 1'b1;
							store_raddr = row_addr(rd_row_q, k_q + COL_W'(1));
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			fill_q  <= fill_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_row_q     <= rd_row_d;
		k_q          <= k_d;
		out_byte_q   <= out_byte_d;
		byte_valid_q <= byte_valid_d;
		out_last_q   <= out_last_d;
		was_empty_q  <= was_empty_d;
		occupancy_q  <= occupancy_d;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_byte   = out_byte_q;
	assign rsp.byte_valid = byte_valid_q;
	assign rsp.out_last   = out_last_q;
	assign rsp.was_empty  = was_empty_q;
	assign rsp.occupancy  = occupancy_q;

endmodule

@@ rtl/core/orq_ram.sv @@
module orq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ test/string_queue_checker.sv @@
module string_queue_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [orq_pkg::APB_AW-1:0] paddr,
	input  logic [orq_pkg::APB_DW-1:0] pwdata,
	orq_req_if                         req,
	orq_rsp_if                         rsp,
	output int                         mismatches,
	output int                         awaited
);
	timeunit 1ns;
	timeprecision 1ps;

	import orq_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              real_byte;
		logic              last;
		logic              empty;
		logic [OCC_W-1:0]  occ;
	} deq_beat_t;

	deq_beat_t beats_due[$];

	logic [BYTE_W-1:0]      string_mem [MAX_ROWS][MAX_ROW_BYTES];
	int                     string_len [MAX_ROWS];
	int                     head;
	int                     tail;
	int                     held;
	int                     fill;
	logic [ROWS_CFG_W-1:0]  rows_cfg;
	logic [BYTES_CFG_W-1:0] bytes_cfg;

	function automatic int rows_used();
		int r;
		r = int'(rows_cfg);
		if (r < 1) r = 1;
		if (r > MAX_ROWS) r = MAX_ROWS;
		return r;
	endfunction

	function automatic int keep_limit();
		int c;
		c = int'(bytes_cfg);
		if (c < 2) c = 2;
		if (c > MAX_ROW_BYTES) c = MAX_ROW_BYTES;
		return c - 1;
	endfunction

	function automatic int wrap_next(input int idx, input int rows);
		return (idx + 1 >= rows) ? 0 : idx + 1;
	endfunction

	// model update and expected dequeue results for one accepted transaction
	task automatic take_item(input logic op, input logic [BYTE_W-1:0] b, input logic hb,
		input logic il);
		int rows;
		int lim;
		int len;
		int h;
		rows = rows_used();
		if (orq_op_t'(op) == OP_ENQ) begin
			lim = keep_limit();
			if (hb && fill < lim) begin
				string_mem[tail][fill] = b;
				fill++;
			end
			if (il) begin
				len = (fill < lim) ? fill : lim;
				if (held >= rows) begin
					// ring full: oldest string is overwritten
					head = wrap_next(head, rows);
					held = rows;
				end else begin
					held++;
				end
				string_len[tail] = len;
				tail = wrap_next(tail, rows);
				fill = 0;
			end
		end else if (held == 0) begin
			beats_due.push_back('{data: '0, real_byte: 1'b0, last: 1'b1, empty: 1'b1, occ: '0});
		end else begin
			h = head;
			len = string_len[h];
			if (len > MAX_ROW_BYTES - 1) len = MAX_ROW_BYTES - 1;
			held--;
			head = wrap_next(head, rows);
			if (len == 0) begin
				beats_due.push_back('{data: '0, real_byte: 1'b0, last: 1'b1, empty: 1'b0,
					occ: OCC_W'(held)});
			end else begin
				for (int k = 0; k < len; k++) begin
					beats_due.push_back('{data: string_mem[h][k], real_byte: 1'b1,
						last: (k == len - 1), empty: 1'b0, occ: OCC_W'(held)});
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deq_beat_t got;
		deq_beat_t want;
		if (!arst_n) begin
			beats_due.delete();
			head = 0;
			tail = 0;
			held = 0;
			fill = 0;
			rows_cfg = ROWS_RESET;
			bytes_cfg = BYTES_RESET;
			mismatches = 0;
			awaited = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (orq_reg_t'(paddr[REG_IDX_LSB]) == REG_ROWS) begin
					rows_cfg = pwdata[ROWS_CFG_W-1:0];
				end else begin
					bytes_cfg = pwdata[BYTES_CFG_W-1:0];
				end
			end
			if (rsp.valid && rsp.ready) begin
				got = '{data: rsp.out_byte, real_byte: rsp.byte_valid, last: rsp.out_last,
					empty: rsp.was_empty, occ: rsp.occupancy};
				if (beats_due.size() == 0) begin
					$display("ERROR %0t: result with nothing expected: byte=%02h valid=%b last=%b empty=%b occ=%0d",
						$time, got.data, got.real_byte, got.last, got.empty, got.occ);
					mismatches++;
				end else begin
					want = beats_due.pop_front();
					if (got !== want) begin
						$display("ERROR %0t: expected byte=%02h valid=%b last=%b empty=%b occ=%0d",
							$time, want.data, want.real_byte, want.last, want.empty, want.occ);
						$display("ERROR %0t:   actual byte=%02h valid=%b last=%b empty=%b occ=%0d",
							$time, got.data, got.real_byte, got.last, got.empty, got.occ);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				take_item(req.op, req.in_byte, req.has_byte, req.is_last);
			end
			awaited = beats_due.size();
		end
	end

endmodule

@@ test/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import orq_pkg::*;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	orq_req_if req_ch();
	orq_rsp_if rsp_ch();

	int       mismatches;
	int       awaited;
	int       burst_left = 0;
	int       hold_asks = 0;
	int       holds_served = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode = RX_FREE;

	overwrite_ring_queue_of_strings_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	string_queue_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_asks != holds_served) begin
			holds_served = hold_asks;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: rsp_ch.ready <= 1'b1;
				RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic offer_item(input orq_op_t op, input logic [BYTE_W-1:0] b, input logic hb,
		input logic il);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.in_byte <= b;
		req_ch.has_byte <= hb;
		req_ch.is_last <= il;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
	endtask

	task automatic offer_dequeue();
		offer_item(OP_DEQ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// one string of n items, or one empty closing item for n = 0, closed by is_last when close is set
	task automatic offer_string(input int n, input bit close, input bit mix_deq);
		if (n == 0 && close) begin
			offer_item(OP_ENQ, BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
		for (int i = 0; i < n; i++) begin
			if (mix_deq && $urandom_range(0, 11) == 0) offer_dequeue();
			offer_item(OP_ENQ, BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
				close && (i == n - 1));
		end
	endtask

	task automatic offer_mix(input int n, input int typ_len);
		int start;
		int pick;
		int len;
		start = 0;
		while (start < n) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 34) :
					$urandom_range(0, typ_len + 1);
				offer_string(len, $urandom_range(0, 9) != 0, 1'b1);
				start += (len == 0) ? 1 : len;
			end else if (pick < 9) begin
				offer_dequeue();
				start++;
			end else begin
				offer_item(orq_op_t'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				start++;
			end
		end
	endtask

	// no transaction in flight and nothing expected, then a wait for enqueues to land
	task automatic settle_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (awaited != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input orq_reg_t r, input int v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(r) << REG_IDX_LSB;
		pwdata <= APB_DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int rows_set[8];
		int bytes_set[8];
		int typ_set[8];
		rows_set = '{1, 0, 31, 4, 16, 3, 2, 7};
		bytes_set = '{2, 0, 63, 5, 2, 32, 1, 10};
		typ_set = '{1, 1, 31, 4, 1, 31, 1, 9};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ENQ;
		req_ch.in_byte = '0;
		req_ch.has_byte = 1'b0;
		req_ch.is_last = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer_dequeue();
		offer_item(OP_ENQ, 8'h00, 1'b1, 1'b0);
		offer_item(OP_ENQ, 8'hFF, 1'b1, 1'b1);
		offer_item(OP_ENQ, 8'hA5, 1'b0, 1'b1);
		offer_item(OP_ENQ, 8'h5A, 1'b1, 1'b0);
		offer_item(OP_ENQ, 8'h3C, 1'b0, 1'b0);
		offer_item(OP_ENQ, 8'hC3, 1'b1, 1'b1);
		repeat (3) offer_dequeue();
		offer_dequeue();

		// wrap the ring so every row holds a committed string before any reconfiguration
		repeat (17) offer_string($urandom_range(1, 3), 1'b1, 1'b0);
		// ring full: the row being filled is the head row
		offer_string(2, 1'b0, 1'b0);
		offer_dequeue();
		offer_item(OP_ENQ, BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
		offer_mix(25, 6);

		for (int p = 0; p < 8; p++) begin
			settle_idle();
			apb_write(REG_ROWS, rows_set[p]);
			apb_write(REG_ROW_BYTES, bytes_set[p]);
			if (p == 0 || p == 4) begin
				hold_asks++;
				offer_string(3, 1'b1, 1'b0);
				offer_dequeue();
				offer_dequeue();
			end
			offer_mix(22, typ_set[p]);
		end
		settle_idle();
		repeat (8) @(negedge clk);

		if (mismatches == 0 && awaited == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
